FILE: rtl/ir_ambient_rejected_distance_unit_defines.svh
// Assertion macros shared by the RTL of the ambient-rejected distance unit.
// Every macro samples on the rising edge of clock and is disabled in reset.
`ifndef IR_AMBIENT_REJECTED_DISTANCE_UNIT_DEFINES_SVH
`define IR_AMBIENT_REJECTED_DISTANCE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// A condition that holds at every clock edge.
`define ARD_ASSERT(name, expr) \
   name: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("ir_ard check failed");
// A condition that implies another one in the same cycle.
`define ARD_ASSERT_IMPL(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ir_ard check failed");
// A condition that implies another one in the next cycle.
`define ARD_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ir_ard check failed");
`else
`define ARD_ASSERT(name, expr)
`define ARD_ASSERT_IMPL(name, ante, cons)
`define ARD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

FILE: rtl/ir_ard_pkg.sv
`default_nettype none
package ir_ard_pkg;

   // Samples per reading of each kind; must be a power of two.
   localparam int SAMPLES_LOG2 = 3;
   localparam int SAMPLES      = 1 << SAMPLES_LOG2;
   localparam int CNT_W        = $clog2(SAMPLES + 1);
   localparam int TOTAL_W      = 18;

   // Distance clamp in millimeters.
   localparam logic [11:0] MAX_MM_Q4 = 12'd3520;
   // ln(2) in Q32.
   localparam logic [31:0] LN2_Q32 = 32'd2977044472;
   // Reciprocal of ten in Q16, exact for the clamped millimeter range.
   localparam logic [12:0] RECIP_TEN_Q16 = 13'd6554;

   // Output status codes.
   localparam logic [1:0] STATUS_CURVE        = 2'd0;
   localparam logic [1:0] STATUS_NO_SIGNAL    = 2'd1;
   localparam logic [1:0] STATUS_OUT_OF_CURVE = 2'd2;
   localparam logic [1:0] STATUS_RAW          = 2'd3;

   // Output unit codes.
   localparam logic [1:0] UNIT_RAW = 2'd0;
   localparam logic [1:0] UNIT_MM  = 2'd1;
   localparam logic [1:0] UNIT_CM  = 2'd2;

   // Configuration register indexes.
   localparam logic [1:0] CSR_CURVE_A = 2'd0;
   localparam logic [1:0] CSR_CURVE_B = 2'd1;
   localparam logic [1:0] CSR_CURVE_C = 2'd2;

   // Reset values of the curve registers.
   localparam logic [15:0] CURVE_A_RESET = 16'd43106;
   localparam logic [15:0] CURVE_B_RESET = 16'd1946;
   localparam logic [15:0] CURVE_C_RESET = 16'd4723;

   typedef struct packed {
      logic [11:0] sample;
      logic        emitter_lit;
      logic [1:0]  unit;
   } req_type;

   typedef struct packed {
      logic signed [16:0] value;
      logic [1:0]         status;
   } rsp_type;

   typedef struct packed {
      logic [15:0] curve_a;
      logic [15:0] curve_b;
      logic [15:0] curve_c;
   } curve_cfg_type;

endpackage
`default_nettype wire

FILE: rtl/ir_ambient_rejected_distance_unit.sv
// Ambient-rejected infrared distance unit.
// Requests carry one 12-bit converter sample, a flag telling whether the
// emitter was lit, and the output unit. Requests move on req_valid/req_ready,
// results on rsp_valid/rsp_ready; a request is taken at an edge where valid
// and ready are both high. Curve registers A, B and C are written through
// csr_we/csr_index/csr_wdata; the user must write them only while the unit is idle (not enforced).
// Ambient and active samples are summed separately. Every request that does
// not complete a reading gives no result. The active request that completes
// a reading starts the curve engine. In curve mode the engine runs a
// normalization, sixteen bit-serial squarings, a serial multiply by ln(2)
// and a restoring division; a zero or negative logarithm skips the
// division. Raw mode and the special cases go straight to the output
// state. req_ready stays low while the engine runs.
// The result sits in an output register, so samples of the next reading
// are taken while it waits for rsp_ready; a stalled receiver only holds the
// engine in its final state. Synchronous reset clears the sums, counts and
// handshake state and reloads the curve registers with their defaults.
`default_nettype none
`include "ir_ambient_rejected_distance_unit_defines.svh"
module ir_ambient_rejected_distance_unit (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_ready,
   input  ir_ard_pkg::req_type req_payload,
   output logic                rsp_valid,
   input  wire                 rsp_ready,
   output ir_ard_pkg::rsp_type rsp_payload,
   input  wire                 csr_we,
   input  wire  [1:0]          csr_index,
   input  wire  [15:0]         csr_wdata
);
   import ir_ard_pkg::*;

   curve_cfg_type      cfg_ff;
   logic [TOTAL_W-1:0] amb_total_ff, amb_total_in;
   logic [TOTAL_W-1:0] act_total_ff, act_total_in;
   logic [CNT_W-1:0]   amb_cnt_ff, amb_cnt_in;
   logic [CNT_W-1:0]   act_cnt_ff, act_cnt_in;
   logic               rsp_valid_ff;
   rsp_type            rsp_payload_ff;

   logic               accept;
   logic               eng_start, eng_idle, eng_done, out_free;
   logic [TOTAL_W-1:0] act_sum;
   logic [CNT_W-1:0]   act_cnt_next;
   logic signed [18:0] total_diff;
   logic [18:0]        diff_mag;
   logic [22:0]        scaled_mag;
   logic signed [16:0] diff_q4;
   rsp_type            eng_result;

   localparam logic [CNT_W-1:0] SAMPLES_W = CNT_W'(SAMPLES);

   // Curve configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.curve_a <= CURVE_A_RESET;
         cfg_ff.curve_b <= CURVE_B_RESET;
         cfg_ff.curve_c <= CURVE_C_RESET;
      end else if (csr_we) begin
         if (csr_index == CSR_CURVE_A) cfg_ff.curve_a <= csr_wdata;
         if (csr_index == CSR_CURVE_B) cfg_ff.curve_b <= csr_wdata;
         if (csr_index == CSR_CURVE_C) cfg_ff.curve_c <= csr_wdata;
      end
   end

   assign accept       = req_valid && req_ready;
   assign req_ready    = eng_idle;
   assign act_sum      = act_total_ff + TOTAL_W'(req_payload.sample);
   assign act_cnt_next = act_cnt_ff + CNT_W'(1);
   assign eng_start    = accept && req_payload.emitter_lit && (act_cnt_next == SAMPLES_W);

   // Averaged difference in sixteenths, truncated toward zero.
   assign total_diff = $signed({1'b0, amb_total_ff}) - $signed({1'b0, act_sum});
   assign diff_mag   = total_diff[18] ? 19'(-total_diff) : 19'(total_diff);
   assign scaled_mag = {diff_mag, 4'd0} >> SAMPLES_LOG2;
   assign diff_q4    = total_diff[18] ? 17'(-$signed({1'b0, scaled_mag[16:0]}))
                                      : $signed(scaled_mag[16:0]);

   // Sample accumulation.
   always_comb begin
      amb_total_in = amb_total_ff;
      act_total_in = act_total_ff;
      amb_cnt_in   = amb_cnt_ff;
      act_cnt_in   = act_cnt_ff;
      if (accept) begin
         priority if (eng_start) begin
            amb_total_in = '0;
            act_total_in = '0;
            amb_cnt_in   = '0;
            act_cnt_in   = '0;
         end else if (req_payload.emitter_lit) begin
            act_total_in = act_sum;
            act_cnt_in   = act_cnt_next;
         end else if (amb_cnt_ff < SAMPLES_W) begin
            amb_total_in = amb_total_ff + TOTAL_W'(req_payload.sample);
            amb_cnt_in   = amb_cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amb_total_ff <= '0;
         act_total_ff <= '0;
         amb_cnt_ff   <= '0;
         act_cnt_ff   <= '0;
      end else begin
         amb_total_ff <= amb_total_in;
         act_total_ff <= act_total_in;
         amb_cnt_ff   <= amb_cnt_in;
         act_cnt_ff   <= act_cnt_in;
      end
   end

   ir_ard_curve u_curve (
      .clock    (clock),
      .reset    (reset),
      .start    (eng_start),
      .diff     (diff_q4),
      .unit     (req_payload.unit),
      .cfg      (cfg_ff),
      .out_free (out_free),
      .idle     (eng_idle),
      .done     (eng_done),
      .result   (eng_result)
   );

   // Output register.
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (eng_done) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (eng_done) begin
         rsp_payload_ff <= eng_result;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `ARD_ASSERT_IMPL(a_start_when_idle, eng_start, eng_idle)
   `ARD_ASSERT_NEXT(a_clear_after_start, eng_start, act_cnt_ff == '0 && amb_cnt_ff == '0)
   `ARD_ASSERT(a_count_bound, amb_cnt_ff <= SAMPLES_W && act_cnt_ff < SAMPLES_W)
   `ARD_ASSERT_IMPL(a_done_needs_room, eng_done, !rsp_valid_ff || rsp_ready)

endmodule
`default_nettype wire

FILE: rtl/ir_ard_curve.sv
`default_nettype none
module ir_ard_curve (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  wire  signed [16:0]        diff,
   input  wire  [1:0]                unit,
   input  ir_ard_pkg::curve_cfg_type cfg,
   input  wire                       out_free,
   output logic                      idle,
   output logic                      done,
   output ir_ard_pkg::rsp_type       result
);
   import ir_ard_pkg::*;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_NORM  = 9'b000000010,
      ST_SQ    = 9'b000000100,
      ST_SQFIN = 9'b000001000,
      ST_LN    = 9'b000010000,
      ST_LNFIN = 9'b000100000,
      ST_DIV   = 9'b001000000,
      ST_FIN   = 9'b010000000,
      ST_OUT   = 9'b100000000
   } state_type;

   state_type          state_ff, state_in;
   logic signed [16:0] d_ff, d_in;
   logic [1:0]         unit_ff, unit_in;
   logic [31:0]        m_ff, m_in;
   logic [31:0]        mr_ff, mr_in;
   logic [63:0]        acc_ff, acc_in;
   logic [3:0]         p_ff, p_in;
   logic [15:0]        f_ff, f_in;
   logic [4:0]         bit_cnt_ff, bit_cnt_in;
   logic [3:0]         step_cnt_ff, step_cnt_in;
   logic [19:0]        rem_ff, rem_in;
   logic [19:0]        lnmag_ff, lnmag_in;
   logic               neg_ff, neg_in;
   logic [11:0]        mm_ff, mm_in;
   logic [1:0]         status_ff, status_in;

   logic signed [17:0] x_wide;
   logic [31:0]        mcand;
   logic [32:0]        psum;
   logic [15:0]        f_next;
   logic signed [4:0]  exp_part;
   logic signed [20:0] l2;
   logic [20:0]        l2_mag;
   logic [20:0]        trial;
   logic               trial_ge;
   logic [32:0]        q_minus_c;

   // Shared shift-add step: one multiplier bit per cycle into the top half.
   assign mcand = (state_ff == ST_LN) ? LN2_Q32 : m_ff;
   assign psum  = {1'b0, acc_ff[63:32]} + (mr_ff[0] ? {1'b0, mcand} : 33'd0);

   // Difference above the curve offset.
   assign x_wide = 18'(diff) - $signed({2'b00, cfg.curve_b});

   // Next fraction bit of the base-two logarithm and the signed result.
   assign f_next   = {f_ff[14:0], acc_ff[63]};
   assign exp_part = $signed({1'b0, p_ff}) - 5'sd4;
   assign l2       = {exp_part, f_next};
   assign l2_mag   = l2[20] ? 21'(-l2) : 21'(l2);

   // Restoring division step.
   assign trial    = {rem_ff, m_ff[31]};
   assign trial_ge = trial >= {1'b0, lnmag_ff};

   assign q_minus_c = {1'b0, m_ff} - {17'd0, cfg.curve_c};

   always_comb begin
      state_in    = state_ff;
      d_in        = d_ff;
      unit_in     = unit_ff;
      m_in        = m_ff;
      mr_in       = mr_ff;
      acc_in      = acc_ff;
      p_in        = p_ff;
      f_in        = f_ff;
      bit_cnt_in  = bit_cnt_ff;
      step_cnt_in = step_cnt_ff;
      rem_in      = rem_ff;
      lnmag_in    = lnmag_ff;
      neg_in      = neg_ff;
      mm_in       = mm_ff;
      status_in   = status_ff;
      done        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               d_in    = diff;
               unit_in = unit;
               mm_in   = MAX_MM_Q4;
               m_in    = {x_wide[15:0], 16'd0};
               p_in    = 4'd15;
               f_in    = '0;
               step_cnt_in = '0;
               priority if (unit == UNIT_RAW) begin
                  status_in = STATUS_RAW;
                  state_in  = ST_OUT;
               end else if (diff <= 17'sd16) begin
                  status_in = STATUS_NO_SIGNAL;
                  state_in  = ST_OUT;
               end else if (x_wide <= 18'sd0) begin
                  status_in = STATUS_OUT_OF_CURVE;
                  state_in  = ST_OUT;
               end else begin
                  status_in = STATUS_CURVE;
                  state_in  = ST_NORM;
               end
            end
         end
         // Normalize so the leading one sits at bit 31.
         ST_NORM: begin
            if (m_ff[31]) begin
               mr_in      = m_ff;
               acc_in     = '0;
               bit_cnt_in = '0;
               state_in   = ST_SQ;
            end else begin
               m_in = {m_ff[30:0], 1'b0};
               p_in = p_ff - 4'd1;
            end
         end
         // Square the mantissa, or multiply the logarithm by ln(2), one bit per cycle.
         ST_SQ, ST_LN: begin
            acc_in     = {psum, acc_ff[31:1]};
            mr_in      = {1'b0, mr_ff[31:1]};
            bit_cnt_in = bit_cnt_ff + 5'd1;
            if (bit_cnt_ff == 5'd31) begin
               state_in = (state_ff == ST_SQ) ? ST_SQFIN : ST_LNFIN;
            end
         end
         // Renormalize the square and take one fraction bit; after the last squaring, start the ln(2) multiply.
         ST_SQFIN: begin
            m_in        = acc_ff[63] ? acc_ff[63:32] : acc_ff[62:31];
            f_in        = f_next;
            step_cnt_in = step_cnt_ff + 4'd1;
            acc_in      = '0;
            bit_cnt_in  = '0;
            if (step_cnt_ff == 4'd15) begin
               neg_in   = l2[20];
               mr_in    = {12'd0, l2_mag[19:0]};
               state_in = ST_LN;
            end else begin
               mr_in    = acc_ff[63] ? acc_ff[63:32] : acc_ff[62:31];
               state_in = ST_SQ;
            end
         end
         // Natural logarithm magnitude is known; pick the path.
         ST_LNFIN: begin
            lnmag_in   = acc_ff[51:32];
            m_in       = {cfg.curve_a, 16'd0};
            rem_in     = '0;
            bit_cnt_in = '0;
            priority if (acc_ff[51:32] == 20'd0) begin
               mm_in    = MAX_MM_Q4;
               state_in = ST_OUT;
            end else if (neg_ff) begin
               mm_in    = '0;
               state_in = ST_OUT;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in     = trial_ge ? 20'(trial - {1'b0, lnmag_ff}) : trial[19:0];
            m_in       = {m_ff[30:0], trial_ge};
            bit_cnt_in = bit_cnt_ff + 5'd1;
            if (bit_cnt_ff == 5'd31) begin
               state_in = ST_FIN;
            end
         end
         // Subtract C and clamp to the curve range.
         ST_FIN: begin
            priority if (q_minus_c[32] || q_minus_c == 33'd0) begin
               mm_in = '0;
            end else if (q_minus_c > {21'd0, MAX_MM_Q4}) begin
               mm_in = MAX_MM_Q4;
            end else begin
               mm_in = q_minus_c[11:0];
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      d_ff        <= d_in;
      unit_ff     <= unit_in;
      m_ff        <= m_in;
      mr_ff       <= mr_in;
      acc_ff      <= acc_in;
      p_ff        <= p_in;
      f_ff        <= f_in;
      bit_cnt_ff  <= bit_cnt_in;
      step_cnt_ff <= step_cnt_in;
      rem_ff      <= rem_in;
      lnmag_ff    <= lnmag_in;
      neg_ff      <= neg_in;
      mm_ff       <= mm_in;
      status_ff   <= status_in;
   end

   // Result selection by status and unit.
   logic [25:0] cm_full;
   assign cm_full = ({1'b0, mm_ff} + 13'd5) * RECIP_TEN_Q16;

   always_comb begin
      result.status = status_ff;
      priority if (status_ff == STATUS_RAW) begin
         result.value = d_ff;
      end else if (unit_ff == UNIT_CM) begin
         result.value = $signed({7'd0, cm_full[25:16]});
      end else begin
         result.value = $signed({5'd0, mm_ff});
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule
`default_nettype wire
